// File: hw/rtl/lpsm_pkg.sv
// shared types, codes and constants of the linear probe slot map
package lpsm_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned SlotW   = 12;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned LimitW  = 13;

  // default table size and the hard cap on allocated slots
  localparam int unsigned DefaultBuckets = 4096;
  localparam int unsigned SlotsMax       = 4096;

  localparam logic [LimitW-1:0] LimitReset = 13'd4096;

  // command codes
  localparam logic [CmdW-1:0] CmdLookup = 2'd0;
  localparam logic [CmdW-1:0] CmdInsert = 2'd1;
  localparam logic [CmdW-1:0] CmdClear  = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StsFound      = 3'd0;
  localparam logic [StatusW-1:0] StsInserted   = 3'd1;
  localparam logic [StatusW-1:0] StsNotFound   = 3'd2;
  localparam logic [StatusW-1:0] StsPresent    = 3'd3;
  localparam logic [StatusW-1:0] StsRegionFull = 3'd4;
  localparam logic [StatusW-1:0] StsTableFull  = 3'd5;
  localparam logic [StatusW-1:0] StsZeroClear  = 3'd6;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OpTrivial,
    OpClear,
    OpLookup,
    OpInsert
  } op_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [StatusW-1:0] status;
  } result_t;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] key;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic sweeping;
  } back_status_t;

endpackage

// File: hw/rtl/lpsm_ram.sv
// generic simple dual-port ram, one write and one registered read port
module lpsm_ram #(
  parameter int unsigned WIDTH = lpsm_pkg::KeyW,
  parameter int unsigned DEPTH = lpsm_pkg::DefaultBuckets
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lpsm_front.sv
// front end: accepts items and classifies them into back-end jobs
module lpsm_front (
  input  lpsm_pkg::in_item_t      item_i,
  input  logic                    start,
  output logic                    busy,
  input  lpsm_pkg::queue_status_t queue_status_i,
  input  lpsm_pkg::back_status_t  back_status_i,
  output logic                    push_o,
  output lpsm_pkg::job_t          job_o
);

  assign busy   = queue_status_i.full | back_status_i.sweeping;
  assign push_o = start & ~busy;

  always_comb begin
    job_o.key = item_i.key;
    job_o.op  = lpsm_pkg::OpTrivial;
    if (item_i.command == lpsm_pkg::CmdClear) begin
      job_o.op = lpsm_pkg::OpClear;
    end else if (item_i.command inside {lpsm_pkg::CmdLookup, lpsm_pkg::CmdInsert}) begin
      // zero key answers without touching the table
      if (item_i.key != '0) begin
        job_o.op = (item_i.command == lpsm_pkg::CmdInsert) ? lpsm_pkg::OpInsert
                                                           : lpsm_pkg::OpLookup;
      end
    end
  end

endmodule

// File: hw/rtl/lpsm_queue.sv
// two-entry job queue between front and back
module lpsm_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lpsm_pkg::job_t          push_data_i,
  input  logic                    pop_i,
  output lpsm_pkg::job_t          head_o,
  output lpsm_pkg::queue_status_t status_o
);

  lpsm_pkg::job_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

endmodule

// File: hw/rtl/lpsm_back.sv
// back end: probe sequencer, slot counter and table sweep
module lpsm_back #(
  parameter int unsigned BUCKETS = lpsm_pkg::DefaultBuckets
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [lpsm_pkg::LimitW-1:0]        slot_limit_i,
  input  logic                               job_valid_i,
  input  lpsm_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               res_valid_o,
  output lpsm_pkg::result_t                  res_o,
  output lpsm_pkg::back_status_t             status_o
);

  localparam int unsigned IdxW = $clog2(BUCKETS);
  localparam int unsigned OffW = IdxW + 1;
  localparam logic [IdxW-1:0] IdxMask = IdxW'(BUCKETS - 1);
  localparam logic [OffW-1:0] OffEnd  = OffW'(BUCKETS);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StProbe = 2'd1;
  localparam logic [1:0] StSweep = 2'd2;

  typedef struct packed {
    logic                          used;
    logic [lpsm_pkg::SlotW-1:0]    slot;
    logic [lpsm_pkg::KeyW-1:0]     key;
  } bucket_t;

  logic [1:0]                  state_q, state_d;
  logic [OffW-1:0]             off_q, off_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [IdxW-1:0]             sweep_q, sweep_d;
  logic [lpsm_pkg::LimitW-1:0] cnt_q, cnt_d;
  lpsm_pkg::job_t              job_q, job_d;
  logic                        res_valid_q, res_valid_d;
  lpsm_pkg::result_t           res_q, res_d;

  logic                        ram_we, ram_re;
  logic [IdxW-1:0]             ram_waddr, ram_raddr;
  bucket_t                     ram_wdata, ram_rdata;

  logic [lpsm_pkg::LimitW-1:0] eff_limit;
  logic                        hit;
  logic [OffW-1:0]             off_next;

  lpsm_ram #(
    .WIDTH ($bits(bucket_t)),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_limit = (32'(slot_limit_i) > 32'(lpsm_pkg::SlotsMax))
                   ? lpsm_pkg::LimitW'(lpsm_pkg::SlotsMax) : slot_limit_i;
  assign hit       = ram_rdata.used && (ram_rdata.key == job_q.key);
  assign off_next  = off_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    off_d       = off_q;
    idx_d       = idx_q;
    sweep_d     = sweep_q;
    cnt_d       = cnt_q;
    job_d       = job_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    pop_o       = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          case (job_i.op)
            lpsm_pkg::OpClear: begin
              res_valid_d  = 1'b1;
              res_d.status = lpsm_pkg::StsZeroClear;
              cnt_d        = '0;
              sweep_d      = '0;
              state_d      = StSweep;
            end
            lpsm_pkg::OpLookup, lpsm_pkg::OpInsert: begin
              job_d     = job_i;
              off_d     = '0;
              idx_d     = job_i.key[IdxW-1:0] & IdxMask;
              ram_re    = 1'b1;
              ram_raddr = job_i.key[IdxW-1:0] & IdxMask;
              state_d   = StProbe;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_d.status = lpsm_pkg::StsZeroClear;
            end
          endcase
        end
      end
      StProbe: begin
        if (hit) begin
          res_valid_d  = 1'b1;
          res_d.slot   = ram_rdata.slot;
          res_d.status = (job_q.op == lpsm_pkg::OpInsert) ? lpsm_pkg::StsPresent
                                                          : lpsm_pkg::StsFound;
          state_d      = StIdle;
        end else if (!ram_rdata.used) begin
          res_valid_d = 1'b1;
          state_d     = StIdle;
          if (job_q.op != lpsm_pkg::OpInsert) begin
            res_d.status = lpsm_pkg::StsNotFound;
          end else if (cnt_q < eff_limit) begin
            ram_we         = 1'b1;
            ram_wdata.used = 1'b1;
            ram_wdata.slot = cnt_q[lpsm_pkg::SlotW-1:0];
            ram_wdata.key  = job_q.key;
            res_d.slot     = cnt_q[lpsm_pkg::SlotW-1:0];
            res_d.status   = lpsm_pkg::StsInserted;
            cnt_d          = cnt_q + 1'b1;
          end else begin
            res_d.status = lpsm_pkg::StsRegionFull;
          end
        end else if (off_next == OffEnd) begin
          // wrapped all the way round with no match and no hole
          res_valid_d  = 1'b1;
          res_d.status = lpsm_pkg::StsTableFull;
          state_d      = StIdle;
        end else begin
          off_d     = off_next;
          idx_d     = (job_q.key[IdxW-1:0] + off_next[IdxW-1:0]) & IdxMask;
          ram_re    = 1'b1;
          ram_raddr = (job_q.key[IdxW-1:0] + off_next[IdxW-1:0]) & IdxMask;
        end
      end
      StSweep: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        if (sweep_q == IdxMask) begin
          state_d = StIdle;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSweep;
      sweep_q     <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    idx_q <= idx_d;
    job_q <= job_d;
    res_q <= res_d;
  end

  assign res_valid_o       = res_valid_q;
  assign res_o             = res_q;
  assign status_o.sweeping = (state_q == StSweep);

  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> job_valid_i)
    else $error("job popped from an empty queue");

  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> !pop_o)
    else $error("job taken while the table is being cleared");

  a_insert_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_d && (res_d.status == lpsm_pkg::StsInserted)) |-> ram_we && ram_wdata.used)
    else $error("insert reported without a table write");

  a_empty_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status != lpsm_pkg::StsFound)
                 && (res_q.status != lpsm_pkg::StsInserted)
                 && (res_q.status != lpsm_pkg::StsPresent)) |-> (res_q.slot == '0))
    else $error("nonzero slot on a result that carries none");

endmodule

// File: hw/rtl/linear_probe_slot_map_unit.sv
// top level of the linear probe slot map: config register, front, queue, back
//
// usage
// - commands enter on item_i when start is high and busy is low; one item per
//   accepting edge (lookup, insert, clear; zero keys and unused codes pass through)
// - every item gives exactly one result on result_o, marked by done_o for a
//   single cycle; results come back in command order and cannot be held off
// - cfg_we_i/cfg_wdata_i write slot_limit; write only while no item is in flight
// - a lookup or insert probes one bucket per cycle, one table read each,
//   until it finds the key or an empty bucket or has wrapped round; the
//   probe loop on the bucket ram read port sets the rate; zero key and
//   unused commands answer without a table read
// - a clear gives its result as the sweep starts, then sweeps the table one
//   bucket per cycle, with busy high
// - after reset busy stays high while the same sweep empties the table;
//   config writes are taken during the sweep
// - a two-entry queue between front and back lets up to two items wait while a
//   long probe run is in progress; busy rises when it is full
// - the receiver never stalls, so results leave the output register every time
module linear_probe_slot_map_unit #(
  parameter int unsigned BUCKETS = lpsm_pkg::DefaultBuckets
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lpsm_pkg::in_item_t          item_i,
  output logic                        done_o,
  output lpsm_pkg::result_t           result_o,
  input  logic                        cfg_we_i,
  input  logic [lpsm_pkg::LimitW-1:0] cfg_wdata_i
);

  // slot limit register
  logic [lpsm_pkg::LimitW-1:0] slot_limit_q, slot_limit_d;

  // front to queue
  logic                    push;
  lpsm_pkg::job_t          push_job;

  // queue to back
  lpsm_pkg::job_t          head_job;
  lpsm_pkg::queue_status_t queue_status;
  logic                    pop;

  // back status seen by the front
  lpsm_pkg::back_status_t  back_status;

  assign slot_limit_d = cfg_we_i ? cfg_wdata_i : slot_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= lpsm_pkg::LimitReset;
    end else begin
      slot_limit_q <= slot_limit_d;
    end
  end

  // accept and classify
  lpsm_front u_front (
    .item_i         (item_i),
    .start          (start),
    .busy           (busy),
    .queue_status_i (queue_status),
    .back_status_i  (back_status),
    .push_o         (push),
    .job_o          (push_job)
  );

  // decoupling queue
  lpsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .status_o    (queue_status)
  );

  // probe engine with the bucket table
  lpsm_back #(
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_limit_i (slot_limit_q),
    .job_valid_i  (!queue_status.empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .res_valid_o  (done_o),
    .res_o        (result_o),
    .status_o     (back_status)
  );

endmodule

// File: tb/sv/slot_map_checker.sv
// checker for the linear probe slot map: predicts every result and compares it
module slot_map_checker
  import lpsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  in_item_t          item_i,
  input  logic              done_i,
  input  result_t           result_i,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  output int                pending_o,
  output int                errors_o
);

  localparam int unsigned Buckets = DefaultBuckets;
  localparam int unsigned IdxW    = $clog2(Buckets);

  // shadow of the table, the slot counter and the limit register
  logic [KeyW-1:0]   bucket_keys  [Buckets];
  logic [SlotW-1:0]  bucket_slots [Buckets];
  bit                bucket_taken [Buckets];
  logic [LimitW-1:0] slots_taken;
  logic [LimitW-1:0] slot_cap;

  result_t           expected_results [$];
  result_t           oldest;
  int                mismatch_total;

  // applies one item to the shadow table and returns the result it gives
  function automatic result_t predict_result(in_item_t cmd_item);
    result_t           res;
    logic [IdxW-1:0]   idx;
    int unsigned       off;
    bit                stop;
    logic [LimitW-1:0] cap;
    res.slot   = '0;
    res.status = StsZeroClear;
    idx        = '0;
    off        = 0;
    stop       = 1'b0;
    if (cmd_item.command == CmdClear) begin
      foreach (bucket_taken[i]) bucket_taken[i] = 1'b0;
      slots_taken = '0;
    end else if ((cmd_item.command == CmdLookup || cmd_item.command == CmdInsert) &&
                 cmd_item.key != '0) begin
      // linear probe with wrap, stop at an empty bucket or the key itself
      while (!stop && off < Buckets) begin
        idx = IdxW'(cmd_item.key + off);
        if (!bucket_taken[idx] || bucket_keys[idx] == cmd_item.key) begin
          stop = 1'b1;
        end else begin
          off++;
        end
      end
      if (!stop) begin
        res.status = StsTableFull;
      end else if (bucket_taken[idx]) begin
        res.slot   = bucket_slots[idx];
        res.status = (cmd_item.command == CmdLookup) ? StsFound : StsPresent;
      end else if (cmd_item.command == CmdLookup) begin
        res.status = StsNotFound;
      end else begin
        cap = (slot_cap > LimitW'(SlotsMax)) ? LimitW'(SlotsMax) : slot_cap;
        if (slots_taken < cap) begin
          res.slot          = slots_taken[SlotW-1:0];
          res.status        = StsInserted;
          bucket_keys[idx]  = cmd_item.key;
          bucket_slots[idx] = res.slot;
          bucket_taken[idx] = 1'b1;
          slots_taken       = slots_taken + 1'b1;
        end else begin
          res.status = StsRegionFull;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bucket_taken[i]) bucket_taken[i] = 1'b0;
      slots_taken    = '0;
      slot_cap       = LimitReset;
      mismatch_total = 0;
      expected_results.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: result with nothing expected: slot %0d status %0d",
                     $realtime, result_i.slot, result_i.status);
          end
        end else begin
          oldest = expected_results.pop_front();
          if (oldest.slot !== result_i.slot || oldest.status !== result_i.status) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                       $realtime, oldest.slot, oldest.status, result_i.slot, result_i.status);
            end
          end
        end
      end
      if (cfg_we_i) begin
        slot_cap = cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(predict_result(item_i));
      end
      pending_o <= expected_results.size();
      errors_o  <= mismatch_total;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// top of the slot map testbench: clock, reset, stimulus, watchdog and verdict
module testbench;
  import lpsm_pkg::*;

  // unused command code, the block answers it like a zero key
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  // longest quiet stretch is a full-table probe or a clear sweep plus a sender
  // gap; allow several times that
  localparam int QuietLimit    = 20000;
  localparam int SettleCycles  = 8;
  localparam int TailCycles    = 16;
  localparam int Phases        = 6;
  localparam int ItemsPerPhase = 210;
  localparam int PoolDepth     = 64;
  // keys sharing one home bucket, enough for long probe runs across the wrap
  localparam int unsigned FillRun = 200;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  in_item_t            item_i      = '0;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i    = 1'b0;
  logic [LimitW-1:0]   cfg_wdata_i = '0;

  int                  pending_cnt;
  int                  error_cnt;
  int                  quiet_cycles = 0;
  int                  idle_pct     = 0;
  // recently inserted keys, reused so lookups and inserts hit stored entries
  logic [KeyW-1:0]     key_pool [$];

  linear_probe_slot_map_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  slot_map_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .item_i     (item_i),
    .done_i     (done_o),
    .result_i   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pending_o  (pending_cnt),
    .errors_o   (error_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: any accepted item or result restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offers one item, with random gaps before it, and returns at the edge that
  // takes it; start stays high so back-to-back items see no gap
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{command: cmd, key: key};
    do @(posedge clk_i); while (busy);
    if (cmd == CmdInsert && key != '0) begin
      key_pool.push_back(key);
      if (key_pool.size() > PoolDepth) void'(key_pool.pop_front());
    end
  endtask

  // holds the sender off until every result is back and any sweep is over
  task automatic settle_table();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    settle_table();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mix of stored keys, keys crowding a few home buckets (also across the
  // wrap at the top of the table), fully random keys and the zero key
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned     roll;
    logic [KeyW-1:0] key;
    roll = $urandom_range(99);
    key  = $urandom();
    if (roll < 3) begin
      key = '0;
    end else if (roll < 45 && key_pool.size() != 0) begin
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    end else if (roll < 80) begin
      key[11:0] = ($urandom_range(1) ? 12'd4064 : 12'd0) + 12'($urandom_range(47));
    end
    return key;
  endfunction

  initial begin
    int unsigned       roll;
    logic [CmdW-1:0]   cmd;
    logic [LimitW-1:0] limit;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block sweeps its table after reset with busy high
    settle_table();

    // directed: empty table, zero key, unused command, probe runs with wrap
    send_item(CmdLookup, 32'h0000_0001);
    send_item(CmdInsert, 32'h0000_0000);
    send_item(CmdLookup, 32'h0000_0000);
    send_item(CmdUnused, 32'hFFFF_FFFF);
    send_item(CmdInsert, 32'hFFFF_FFFF);
    send_item(CmdInsert, 32'h0000_0FFF);
    send_item(CmdInsert, 32'h8000_0FFF);
    send_item(CmdLookup, 32'h8000_0FFF);
    send_item(CmdInsert, 32'hFFFF_FFFF);
    send_item(CmdLookup, 32'h7FFF_FFFF);
    send_item(CmdLookup, 32'h0000_1000);
    send_item(CmdClear,  32'hFFFF_FFFF);
    send_item(CmdLookup, 32'hFFFF_FFFF);

    // region full with a tiny limit, then with no slots at all
    write_limit(13'd2);
    send_item(CmdInsert, 32'hA5A5_A5A5);
    send_item(CmdInsert, 32'h5A5A_5A5A);
    send_item(CmdInsert, 32'h1234_5678);
    send_item(CmdInsert, 32'hA5A5_A5A5);
    send_item(CmdLookup, 32'h1234_5678);
    write_limit(13'd0);
    send_item(CmdClear,  32'h0000_0000);
    send_item(CmdInsert, 32'h0000_0001);

    // crowd one home bucket near the top of the table so probe runs grow
    // long and wrap past the last bucket
    write_limit(13'h1FFF);
    send_item(CmdClear, 32'h0000_0000);
    for (int unsigned k = 1; k <= FillRun; k++) begin
      send_item(CmdInsert, KeyW'((k << 12) | 32'h0000_0FF0));
    end
    send_item(CmdLookup, 32'h0007_0FF0);
    send_item(CmdLookup, 32'h0000_0FF0);
    send_item(CmdInsert, 32'h1000_0FF8);
    send_item(CmdInsert, 32'h0001_0FF0);
    send_item(CmdLookup, 32'h0000_0000);
    key_pool.delete();

    // random phases, each with its own limit and one of three sender gap patterns
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0:       limit = 13'h1FFF;
        1:       limit = 13'd300;
        2:       limit = LimitReset;
        3:       limit = 13'd3;
        4:       limit = 13'd4095;
        default: limit = LimitW'($urandom_range(8191));
      endcase
      idle_pct = 0;
      write_limit(limit);
      case (ph % 4)
        1:       idle_pct = 77;
        3:       idle_pct = 38;
        default: idle_pct = 0;
      endcase
      send_item(CmdClear, $urandom());
      repeat (ItemsPerPhase) begin
        // now and then let the block drain completely before going on
        if ($urandom_range(199) == 0) settle_table();
        roll = $urandom_range(99);
        if (roll < 48) begin
          cmd = CmdLookup;
        end else if (roll < 96) begin
          cmd = CmdInsert;
        end else if (roll < 98) begin
          cmd = CmdClear;
        end else begin
          cmd = CmdUnused;
        end
        send_item(cmd, pick_key());
      end
    end

    // drain, let any trailing activity show, then give the verdict
    start <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lpsm_pkg.sv
hw/rtl/lpsm_ram.sv
hw/rtl/lpsm_front.sv
hw/rtl/lpsm_queue.sv
hw/rtl/lpsm_back.sv
hw/rtl/linear_probe_slot_map_unit.sv
tb/sv/slot_map_checker.sv
tb/sv/testbench.sv
